>>> design/itrs_pkg.sv
// ============================================================================
// itrs_pkg - integer to radix string shared definitions
// Widths, character codes, divider sizing and the digit-to-ASCII mapping.
// ============================================================================
package itrs_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // quotient bits resolved per divider cycle
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_QW     = DIV_CYCLES * DIV_BITS;
    localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // digit count: up to VALUE_WIDTH digits in base 2
    localparam int NDIG_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h61;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quot;
        logic [DIGIT_W-1:0]     rem;
    } div_res_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

>>> design/integer_to_radix_string_top.sv
// ============================================================================
// integer_to_radix_string_top - signed integer to ASCII text in radix 2..16
// Emits '-' for negatives, then digits most significant first, tlast on the
// final character.
// ============================================================================
// Each digit costs one pass through the shared divider, then each character
//   leaves through the output register, which holds it while m_axis_tready is low.
// The input is not ready until the last character is loaded, so a new value
//   is taken only once the previous one has its last character in the output register.
// Reset: radix returns to 10, block idle, output empty.
module integer_to_radix_string_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [itrs_pkg::VALUE_WIDTH-1:0] s_axis_tdata,   // [31:0] value
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [itrs_pkg::CHAR_W-1:0]      m_axis_tdata,   // [7:0] character
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [itrs_pkg::RADIX_W-1:0]     cfg_data        // [4:0] radix
);
    import itrs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SIGN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                 state_reg;
    logic [RADIX_W-1:0]     radix_reg;
    logic                   neg_reg;
    logic [NDIG_W-1:0]      ndig_reg;
    logic [DIGIT_W-1:0]     stk_reg [VALUE_WIDTH];
    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      out_char_reg;
    logic                   out_last_reg;

    logic                   in_acc;
    logic                   out_load;
    logic                   char_load;
    logic                   push;
    logic                   pop;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic                   quot_zero;
    div_res_t               div_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign char_load     = ((state_reg == ST_SIGN) || (state_reg == ST_EMIT)) && out_load;

    assign mag_in       = s_axis_tdata[VALUE_WIDTH-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
    assign quot_zero    = (div_res.quot == '0);
    assign push         = (state_reg == ST_DIV) && div_res.done;
    assign pop          = (state_reg == ST_EMIT) && out_load;
    assign div_start    = in_acc || (push && !quot_zero);
    assign div_dividend = (state_reg == ST_IDLE) ? mag_in : div_res.quot;

    itrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .radix    (radix_reg),
        .res      (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_data < RADIX_MIN)
            begin
                radix_reg <= RADIX_MIN;
            end
            else if (cfg_data > RADIX_MAX)
            begin
                radix_reg <= RADIX_MAX;
            end
            else
            begin
                radix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ndig_reg      <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        neg_reg   <= s_axis_tdata[VALUE_WIDTH-1];
                        ndig_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        ndig_reg <= ndig_reg + 1'b1;
                        if (quot_zero)
                        begin
                            state_reg <= neg_reg ? ST_SIGN : ST_EMIT;
                        end
                    end
                end
                ST_SIGN:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_load)
                    begin
                        ndig_reg <= ndig_reg - 1'b1;
                        if (ndig_reg == NDIG_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // digit stack: push at the bottom while dividing, pop from there to emit
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_reg[0] <= div_res.rem;
            for (int i = 1; i < VALUE_WIDTH; i++)
            begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < VALUE_WIDTH - 1; i++)
            begin
                stk_reg[i] <= stk_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SIGN) && out_load)
        begin
            out_char_reg <= CHAR_MINUS;
            out_last_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_char_reg <= digit_char(stk_reg[0]);
            out_last_reg <= (ndig_reg == NDIG_W'(1));
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> design/itrs_div.sv
// ============================================================================
// itrs_div - iterative divider by a small radix
// Restoring division, DIV_BITS quotient bits per cycle; quotient and
// remainder are valid in the cycle that done is high.
// ============================================================================
module itrs_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [itrs_pkg::VALUE_WIDTH-1:0] dividend,
    input  logic [itrs_pkg::RADIX_W-1:0]     radix,
    output itrs_pkg::div_res_t               res
);
    import itrs_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_QW-1:0]    q_reg;
    logic [DIGIT_W-1:0]   r_reg;

    logic [DIV_QW-1:0]    q_next;
    logic [DIGIT_W-1:0]   r_next;
    logic [RADIX_W-1:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        trial  = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial  = {r_next, q_next[DIV_QW-1]};
            q_next = {q_next[DIV_QW-2:0], 1'b0};
            if (trial >= radix)
            begin
                trial     = trial - radix;
                q_next[0] = 1'b1;
            end
            r_next = trial[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= DIV_QW'(dividend);
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign res.done = done_reg;
    assign res.quot = q_reg[VALUE_WIDTH-1:0];
    assign res.rem  = r_reg;

endmodule

>>> design/itrs_checker.sv
// ============================================================================
// itrs_checker - port-level checks for integer_to_radix_string_top
// Output hold under stall, character set, sequencing of input vs. output.
// ============================================================================
module itrs_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [itrs_pkg::VALUE_WIDTH-1:0] s_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [itrs_pkg::CHAR_W-1:0]      m_axis_tdata,
    input  logic                             m_axis_tlast
);
    import itrs_pkg::*;

    logic [CHAR_W-1:0] ch;
    assign ch = m_axis_tdata;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (ch == CHAR_MINUS && !m_axis_tlast)
            || (ch >= CHAR_ZERO && ch <= CHAR_ZERO + 8'd9)
            || (ch >= CHAR_A && ch <= CHAR_A + 8'd5))
        else $error("illegal character or tlast on sign");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_axis_tready) |-> m_axis_tvalid && m_axis_tlast)
        else $error("input ready before last character was loaded");

endmodule

bind integer_to_radix_string_top itrs_checker u_itrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
